// ===== rtl/core/bkenc_pkg.sv =====
// Shared types, key codes and lookup functions for the button edge key event encoder.
`timescale 1ns / 1ps
`default_nettype none

package bkenc_pkg;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'(61 * 8);
    localparam logic [7:0]  PINS_RELEASED    = 8'hFF;

    localparam logic [7:0] HID_SHIFT    = 8'h02;
    localparam logic [7:0] HID_NO_MOD   = 8'h00;
    localparam logic [7:0] HID_SPACE    = 8'h2C;
    localparam logic [7:0] HID_LETTER_B = 8'h05;
    localparam logic [7:0] HID_LETTER_D = 8'h07;
    localparam logic [7:0] HID_LETTER_F = 8'h09;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] PORT_B = 2'd0;
    localparam logic [1:0] PORT_D = 2'd1;
    localparam logic [1:0] PORT_F = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] port_b_pins;
        logic [7:0] port_d_pins;
        logic [7:0] port_f_pins;
    } t_in_item;

    typedef struct packed {
        logic [7:0] key_code;
        logic [7:0] modifier_bits;
        logic       last_of_run;
    } t_out_item;

    // Falling edges, one byte per port, indexed by the port constants.
    typedef logic [2:0][7:0] t_edge_mask;

    typedef struct packed {
        logic       scan;
        logic       space;
        t_edge_mask mask;
    } t_seq_start;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPACE
    } t_seq_state;

    function automatic logic [7:0] digit_code(input logic [2:0] bit_idx);
        logic [7:0] code;
        case (bit_idx)
            3'd0:    code = 8'h27;
            3'd1:    code = 8'h1E;
            3'd2:    code = 8'h1F;
            3'd3:    code = 8'h20;
            3'd4:    code = 8'h21;
            3'd5:    code = 8'h22;
            3'd6:    code = 8'h23;
            3'd7:    code = 8'h24;
            default: code = 8'h27;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] arrow_code(input logic [1:0] bit_idx);
        logic [7:0] code;
        case (bit_idx)
            2'd0:    code = 8'h50;
            2'd1:    code = 8'h52;
            2'd2:    code = 8'h4F;
            2'd3:    code = 8'h51;
            default: code = 8'h50;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] port_letter(input logic [1:0] port);
        logic [7:0] code;
        case (port)
            PORT_B:  code = HID_LETTER_B;
            PORT_D:  code = HID_LETTER_D;
            PORT_F:  code = HID_LETTER_F;
            default: code = HID_LETTER_B;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bkenc_seq.sv =====
// Pin scan sequencer and output register of the key event encoder.
`timescale 1ns / 1ps
`default_nettype none

module bkenc_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bkenc_pkg::t_seq_start i_start,
    output logic                       o_busy,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output bkenc_pkg::t_out_item       o_out_data
);

    bkenc_pkg::t_seq_state r_state, n_state;
    bkenc_pkg::t_edge_mask r_mask, n_mask;
    logic [1:0]            r_port, n_port;
    logic [2:0]            r_bit, n_bit;
    logic                  r_phase, n_phase;
    logic                  r_out_valid, n_out_valid;
    bkenc_pkg::t_out_item  r_out_data, n_out_data;

    bkenc_pkg::t_edge_mask rest;
    logic                  out_free;
    logic                  is_arrow;

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_arrow = (r_port == bkenc_pkg::PORT_B) && !r_bit[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bkenc_pkg::ST_IDLE;
            r_mask      <= '0;
            r_port      <= bkenc_pkg::PORT_B;
            r_bit       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_port      <= n_port;
            r_bit       <= n_bit;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_port      = r_port;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        rest        = r_mask;
        rest[r_port][r_bit] = 1'b0;

        case (r_state)
            bkenc_pkg::ST_IDLE: begin
                if (i_start.scan) begin
                    n_state = bkenc_pkg::ST_SCAN;
                    n_mask  = i_start.mask;
                    n_port  = bkenc_pkg::PORT_B;
                    n_bit   = '0;
                    n_phase = 1'b0;
                end else if (i_start.space) begin
                    n_state = bkenc_pkg::ST_SPACE;
                end
            end
            bkenc_pkg::ST_SCAN: begin
                if (!r_mask[r_port][r_bit]) begin
                    if (r_port == bkenc_pkg::PORT_F) begin
                        n_port = bkenc_pkg::PORT_B;
                        n_bit  = r_bit + 3'd1;
                    end else begin
                        n_port = r_port + 2'd1;
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    if (is_arrow || r_phase) begin
                        n_out_data.key_code      = is_arrow ? bkenc_pkg::arrow_code(r_bit[1:0])
                                                            : bkenc_pkg::digit_code(r_bit);
                        n_out_data.modifier_bits = bkenc_pkg::HID_NO_MOD;
                        n_out_data.last_of_run   = (rest == '0);
                        n_mask  = rest;
                        n_phase = 1'b0;
                        if (rest == '0) begin
                            n_state = bkenc_pkg::ST_IDLE;
                        end else if (r_port == bkenc_pkg::PORT_F) begin
                            n_port = bkenc_pkg::PORT_B;
                            n_bit  = r_bit + 3'd1;
                        end else begin
                            n_port = r_port + 2'd1;
                        end
                    end else begin
                        // A button gives its shifted port letter first, then its digit.
                        n_out_data.key_code      = bkenc_pkg::port_letter(r_port);
                        n_out_data.modifier_bits = bkenc_pkg::HID_SHIFT;
                        n_out_data.last_of_run   = 1'b0;
                        n_phase = 1'b1;
                    end
                end
            end
            bkenc_pkg::ST_SPACE: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_data.key_code      = bkenc_pkg::HID_SPACE;
                    n_out_data.modifier_bits = bkenc_pkg::HID_NO_MOD;
                    n_out_data.last_of_run   = 1'b1;
                    n_state                  = bkenc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bkenc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != bkenc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_idle_mask_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bkenc_pkg::ST_IDLE) |-> (r_mask == '0))
        else $error("edge mask left over after scan");

    a_scan_mask_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bkenc_pkg::ST_SCAN) |-> (r_mask != '0))
        else $error("scan running with no edges left");

    a_digit_pin_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bkenc_pkg::ST_SCAN && r_phase) |-> r_mask[r_port][r_bit])
        else $error("digit phase on a pin without an edge");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start.scan || i_start.space) |-> (r_state == bkenc_pkg::ST_IDLE))
        else $error("sequencer started while busy");

endmodule

`default_nettype wire

// ===== rtl/core/button_edge_key_event_encoder_unit.sv =====
// Top level of the button edge key event encoder: sample registers, idle counter, sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is either a sample of the three active-low button ports or a
// timer tick. A sample is compared with the previous one and every newly pressed pin
// becomes key press transactions, pins taken bit 0 to 7 and ports B, D, F within a bit;
// the last of them carries last_of_run. A single scan pointer steps one pin per cycle,
// waiting on a pressed pin while the output stalls, and stops after the last pressed
// pin; a shifted letter plus digit holds it on that pin for one more key. A sample keeps
// the input stalled until the scan ends, which grows with the position of the last new
// press, each letter key and each output stall. Samples without new presses and ticks
// that emit nothing never stall; a tick past idle_limit starts a space key. Writes to
// idle_limit take effect at once and are meant for an idle block.
module button_edge_key_event_encoder_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bkenc_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bkenc_pkg::t_out_item      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_data
);

    logic [15:0] r_idle_limit;
    logic [15:0] r_idle_ticks, n_idle_ticks;
    logic [7:0]  r_prev_b, r_prev_d, r_prev_f;

    logic                  accept;
    logic                  busy;
    logic [15:0]           ticks_inc;
    bkenc_pkg::t_edge_mask edges;
    bkenc_pkg::t_seq_start start;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign ticks_inc  = r_idle_ticks + 16'd1;

    always_comb begin
        edges = '0;
        edges[bkenc_pkg::PORT_B] = r_prev_b & ~i_in_data.port_b_pins;
        edges[bkenc_pkg::PORT_D] = r_prev_d & ~i_in_data.port_d_pins;
        edges[bkenc_pkg::PORT_F] = r_prev_f & ~i_in_data.port_f_pins;
    end

    always_comb begin
        n_idle_ticks = r_idle_ticks;
        start.scan   = 1'b0;
        start.space  = 1'b0;
        start.mask   = edges;
        if (accept) begin
            if (i_in_data.cmd == bkenc_pkg::CMD_TICK) begin
                if (ticks_inc > r_idle_limit) begin
                    n_idle_ticks = '0;
                    start.space  = 1'b1;
                end else begin
                    n_idle_ticks = ticks_inc;
                end
            end else if (edges != '0) begin
                n_idle_ticks = '0;
                start.scan   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= bkenc_pkg::IDLE_LIMIT_RESET;
            r_idle_ticks <= '0;
            r_prev_b     <= bkenc_pkg::PINS_RELEASED;
            r_prev_d     <= bkenc_pkg::PINS_RELEASED;
            r_prev_f     <= bkenc_pkg::PINS_RELEASED;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_data;
            end
            r_idle_ticks <= n_idle_ticks;
            if (accept && i_in_data.cmd == bkenc_pkg::CMD_SAMPLE) begin
                r_prev_b <= i_in_data.port_b_pins;
                r_prev_d <= i_in_data.port_d_pins;
                r_prev_f <= i_in_data.port_f_pins;
            end
        end
    end

    bkenc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
